[src/pfk_pkg.sv]
// ----------------------------------------------------------------------------
// pfk_pkg: shared types and constants of the Pareto front keeper
// Sizes of the front table, payload structs, and the control and status
// bundles that run between the controller and the chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pfk_pkg;

	localparam int FRONT_DEPTH = 32;
	localparam int VALUE_BITS  = 16;
	localparam int ID_BITS     = 16;
	localparam int CNT_BITS    = $clog2(FRONT_DEPTH + 1);

	localparam logic CMD_INSERT  = 1'b0;
	localparam logic CMD_REMOVE  = 1'b1;
	localparam logic KIND_EVICT  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef logic [VALUE_BITS-1:0]  val_t;
	typedef logic [ID_BITS-1:0]     id_t;
	typedef logic [CNT_BITS-1:0]    cnt_t;
	typedef logic [FRONT_DEPTH-1:0] row_t;

	typedef struct packed {
		id_t  id;
		val_t err;
		val_t cx;
	} cand_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cand_t cand;
		logic  cmp;
		logic  is_ins;
		logic  evict_en;
	} ctl_t;

	// running front summary handed from cell to cell
	typedef struct packed {
		logic have;
		val_t be;
		val_t bc;
		cnt_t cnt;
	} agg_t;

	// per-cell status seen by the controller
	typedef struct packed {
		logic valid;
		logic blk;
		logic dom;
		logic hit;
		logic emit;
		id_t  eid;
	} cell_stat_t;

	typedef struct packed {
		logic       kind;
		logic [15:0] evicted_id;
		logic       admitted;
		logic       removed_found;
		logic       overflow;
		logic [5:0] front_size;
		logic [15:0] best_error;
		logic [15:0] best_complexity;
		logic       last;
	} res_t;

	function automatic row_t lowest_set(input row_t v);
		row_t one;
		one = row_t'(1);
		return v & (~v + one);
	endfunction

endpackage

`default_nettype wire

[src/pfk_ifs.sv]
// ----------------------------------------------------------------------------
// pfk_ifs: channel interfaces of the Pareto front keeper
// Candidate/command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfk_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] cand_id;
	logic [15:0] cand_error;
	logic [15:0] cand_complexity;

	modport source(output valid, cmd, cand_id, cand_error, cand_complexity, input ready);
	modport sink(input valid, cmd, cand_id, cand_error, cand_complexity, output ready);
endinterface

interface pfk_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] evicted_id;
	logic        admitted;
	logic        removed_found;
	logic        overflow;
	logic [5:0]  front_size;
	logic [15:0] best_error;
	logic [15:0] best_complexity;
	logic        last;

	modport source(output valid, kind, evicted_id, admitted, removed_found, overflow,
		front_size, best_error, best_complexity, last, input ready);
	modport sink(input valid, kind, evicted_id, admitted, removed_found, overflow,
		front_size, best_error, best_complexity, last, output ready);
endinterface

`default_nettype wire

[src/pfk_cell.sv]
// ----------------------------------------------------------------------------
// pfk_cell: one slot of the Pareto front
// Holds one entry, latches its dominance flags against the broadcast
// candidate, and on the sweep token applies evict/write/remove and folds
// its entry into the running summary passed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pfk_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pfk_pkg::ctl_t    ctl,
	input  wire logic             sel,
	input  wire logic             advance,
	input  wire logic             tok_in,
	input  wire pfk_pkg::agg_t    agg_in,
	output logic                  tok_out,
	output pfk_pkg::agg_t         agg_out,
	output pfk_pkg::cell_stat_t   stat
);

	logic          valid_q;
	pfk_pkg::id_t  id_q;
	pfk_pkg::val_t err_q;
	pfk_pkg::val_t cx_q;
	logic          blk_q;
	logic          dom_q;
	logic          hit_q;
	logic          tok_q;
	pfk_pkg::agg_t agg_q;

	logic          dup;
	logic          blk_c;
	logic          dom_c;
	logic          hit_c;
	logic          emit;
	logic          wr;
	logic          clr;
	logic          nv;
	pfk_pkg::val_t ne;
	pfk_pkg::val_t nc;
	pfk_pkg::agg_t agg_nx;

	always_comb begin
		dup   = (err_q == ctl.cand.err) && (cx_q == ctl.cand.cx);
		blk_c = valid_q && !dup && (err_q <= ctl.cand.err) && (cx_q <= ctl.cand.cx);
		dom_c = valid_q && !dup && (ctl.cand.err <= err_q) && (ctl.cand.cx <= cx_q);
		hit_c = valid_q && (id_q == ctl.cand.id);

		emit = tok_in && ctl.evict_en && dom_q;
		wr   = tok_in && sel && ctl.is_ins;
		clr  = emit || (tok_in && sel && !ctl.is_ins);

		nv = wr ? 1'b1 : (clr ? 1'b0 : valid_q);
		ne = wr ? ctl.cand.err : err_q;
		nc = wr ? ctl.cand.cx : cx_q;

		agg_nx = agg_in;
		if (nv) begin
			agg_nx.cnt = agg_in.cnt + pfk_pkg::cnt_t'(1);
			if (!agg_in.have || (ne < agg_in.be) || ((ne == agg_in.be) && (nc < agg_in.bc))) begin
				agg_nx.have = 1'b1;
				agg_nx.be   = ne;
				agg_nx.bc   = nc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= 1'b0;
		end else if (advance) begin
			tok_q <= tok_in;
			if (tok_in) begin
				valid_q <= nv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			blk_q <= blk_c;
			dom_q <= dom_c;
			hit_q <= hit_c;
		end
		if (advance && tok_in) begin
			agg_q <= agg_nx;
		end
		if (advance && wr) begin
			id_q  <= ctl.cand.id;
			err_q <= ctl.cand.err;
			cx_q  <= ctl.cand.cx;
		end
	end

	assign tok_out    = tok_q;
	assign agg_out    = agg_q;
	assign stat.valid = valid_q;
	assign stat.blk   = blk_q;
	assign stat.dom   = dom_q;
	assign stat.hit   = hit_q;
	assign stat.emit  = emit;
	assign stat.eid   = emit ? id_q : '0;

endmodule

`default_nettype wire

[src/pareto_front_keeper.sv]
// ----------------------------------------------------------------------------
// pareto_front_keeper: two-objective Pareto front store
// Insert candidates (evicting entries they dominate) or remove entries by
// id; every item ends with a status result carrying size and best entry.
//
//   port    | role | payload
//   --------+------+-------------------------------------------------------
//   cand    | sink | cmd, cand_id, cand_error, cand_complexity
//   result  | src  | kind, evicted_id, admitted, removed_found, overflow,
//           |      | front_size, best_error, best_complexity, last
//
// One item at a time: compare, plan, then a token sweeps the chain of
// FRONT_DEPTH cells one cell per cycle while no eviction report is held
// back. Each eviction report waits in the single output register; a stalled
// result port freezes the sweep only while a cell has an eviction to report.
// Reset clears all slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_front_keeper (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pfk_in_if.sink     cand,
	pfk_out_if.source  result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PLAN,
		ST_LAUNCH,
		ST_SWEEP,
		ST_STAT
	} state_t;

	localparam int D = pfk_pkg::FRONT_DEPTH;

	state_t             state_q;
	pfk_pkg::cand_t     cand_q;
	logic               is_ins_q;
	logic               evict_en_q;
	pfk_pkg::row_t      sel_q;
	logic               adm_q;
	logic               fnd_q;
	logic               ovf_q;
	pfk_pkg::agg_t      fin_q;
	logic               res_v_q;
	pfk_pkg::res_t      res_q;

	pfk_pkg::ctl_t      ctl;
	logic               tok [D+1];
	pfk_pkg::agg_t      agg [D+1];
	pfk_pkg::cell_stat_t stat [D];

	pfk_pkg::row_t      blk_v;
	pfk_pkg::row_t      free_v;
	pfk_pkg::row_t      hit_v;
	logic               emit_any;
	pfk_pkg::id_t       eid;
	logic               out_free;
	logic               advance;
	logic               take;

	assign take     = cand.valid && cand.ready;
	assign out_free = !res_v_q || result.ready;

	always_comb begin
		emit_any = 1'b0;
		eid      = '0;
		for (int i = 0; i < D; i++) begin
			blk_v[i]  = stat[i].blk;
			free_v[i] = !stat[i].valid || stat[i].dom;
			hit_v[i]  = stat[i].hit;
			emit_any  = emit_any | stat[i].emit;
			eid       = eid | stat[i].eid;
		end
	end

	assign advance = !(emit_any && !out_free);

	assign ctl.cand     = cand_q;
	assign ctl.cmp      = (state_q == ST_CMP);
	assign ctl.is_ins   = is_ins_q;
	assign ctl.evict_en = evict_en_q;

	assign tok[0] = (state_q == ST_LAUNCH);
	assign agg[0] = '0;

	for (genvar g = 0; g < D; g++) begin : g_cell
		pfk_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel     (sel_q[g]),
			.advance (advance),
			.tok_in  (tok[g]),
			.agg_in  (agg[g]),
			.tok_out (tok[g+1]),
			.agg_out (agg[g+1]),
			.stat    (stat[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			evict_en_q <= 1'b0;
			sel_q      <= '0;
			res_v_q    <= 1'b0;
		end else begin
			if (emit_any && out_free) begin
				res_v_q <= 1'b1;
			end else if ((state_q == ST_STAT) && out_free) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						evict_en_q <= 1'b0;
						sel_q      <= '0;
						state_q    <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					if (is_ins_q) begin
						if (!(|blk_v)) begin
							evict_en_q <= 1'b1;
							sel_q      <= pfk_pkg::lowest_set(free_v);
						end
					end else begin
						sel_q <= pfk_pkg::lowest_set(hit_v);
					end
					state_q <= ST_LAUNCH;
				end
				ST_LAUNCH: begin
					if (advance) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (tok[D]) begin
						state_q <= ST_STAT;
					end
				end
				ST_STAT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cand_q.id  <= cand.cand_id;
			cand_q.err <= pfk_pkg::val_t'(cand.cand_error);
			cand_q.cx  <= pfk_pkg::val_t'(cand.cand_complexity);
			is_ins_q   <= (cand.cmd == pfk_pkg::CMD_INSERT);
			adm_q      <= 1'b0;
			fnd_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end
		if (state_q == ST_PLAN) begin
			if (is_ins_q) begin
				if (!(|blk_v)) begin
					adm_q <= |free_v;
					ovf_q <= !(|free_v);
				end
			end else begin
				fnd_q <= |hit_v;
			end
		end
		if ((state_q == ST_SWEEP) && tok[D]) begin
			fin_q <= agg[D];
		end

		if (emit_any && out_free) begin
			res_q.kind            <= pfk_pkg::KIND_EVICT;
			res_q.evicted_id      <= 16'(eid);
			res_q.admitted        <= 1'b0;
			res_q.removed_found   <= 1'b0;
			res_q.overflow        <= 1'b0;
			res_q.front_size      <= '0;
			res_q.best_error      <= '0;
			res_q.best_complexity <= '0;
			res_q.last            <= 1'b0;
		end else if ((state_q == ST_STAT) && out_free) begin
			res_q.kind            <= pfk_pkg::KIND_STATUS;
			res_q.evicted_id      <= '0;
			res_q.admitted        <= adm_q;
			res_q.removed_found   <= fnd_q;
			res_q.overflow        <= ovf_q;
			res_q.front_size      <= 6'(fin_q.cnt);
			res_q.best_error      <= 16'(fin_q.be);
			res_q.best_complexity <= 16'(fin_q.bc);
			res_q.last            <= 1'b1;
		end
	end

	assign cand.ready = (state_q == ST_IDLE);

	assign result.valid           = res_v_q;
	assign result.kind            = res_q.kind;
	assign result.evicted_id      = res_q.evicted_id;
	assign result.admitted        = res_q.admitted;
	assign result.removed_found   = res_q.removed_found;
	assign result.overflow        = res_q.overflow;
	assign result.front_size      = res_q.front_size;
	assign result.best_error      = res_q.best_error;
	assign result.best_complexity = res_q.best_complexity;
	assign result.last            = res_q.last;

endmodule

`default_nettype wire
